@@ design/arrt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation range table package
// Shared codes, field widths and parameter defaults for the range table.
// ----------------------------------------------------------------------------
package arrt_pkg;

	localparam int DEF_MAX_ENTRIES = 1024;
	localparam int DEF_ADDR_BITS   = 48;

	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 11;

	typedef enum logic [FUNC_W-1:0] {
		FN_RECORD = 2'd0,
		FN_REMOVE = 2'd1,
		FN_LOOKUP = 2'd2,
		FN_NONE   = 2'd3
	} func_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_BASE = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e_t;

	// Completion handshake from the sequencer to the result register.
	typedef struct packed {
		logic      done;
		status_e_t status;
	} res_ctl_t;

endpackage
`default_nettype wire

@@ design/arrt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Range table entry memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module arrt_ram #(
	parameter int DEPTH  = arrt_pkg::DEF_MAX_ENTRIES,
	parameter int WIDTH  = 2 * arrt_pkg::DEF_ADDR_BITS,
	parameter int IDX_W  = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_idx,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule
`default_nettype wire

@@ design/arrt_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Range table sequencer
// Holds the entry count, appends records, and scans the entry memory one
// slot a cycle for remove and lookup. A remove moves the last entry into
// the freed slot.
// ----------------------------------------------------------------------------
module arrt_seq #(
	parameter int MAX_ENTRIES = arrt_pkg::DEF_MAX_ENTRIES,
	parameter int ADDR_BITS   = arrt_pkg::DEF_ADDR_BITS,
	parameter int IDX_W       = $clog2(MAX_ENTRIES),
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic [arrt_pkg::FUNC_W-1:0] func,
	input  wire logic [ADDR_BITS-1:0]        address,
	input  wire logic [ADDR_BITS-1:0]        region_size,
	output arrt_pkg::res_ctl_t               res_ctl,
	input  wire logic                        res_take,
	output logic      [ADDR_BITS-1:0]        hit_base,
	output logic      [ADDR_BITS-1:0]        hit_size,
	output logic      [CNT_W-1:0]            count,
	output logic                             wr_en,
	output logic      [IDX_W-1:0]            wr_idx,
	output logic      [2*ADDR_BITS-1:0]      wr_data,
	output logic                             rd_en,
	output logic      [IDX_W-1:0]            rd_idx,
	input  wire logic [2*ADDR_BITS-1:0]      rd_data
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SCAN    = 5'b00010,
		S_MOVE_RD = 5'b00100,
		S_MOVE_WR = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	arrt_pkg::func_e_t             op_q;
	logic [ADDR_BITS-1:0]          key_q;
	logic [CNT_W-1:0]              issue_q;
	logic                          vld_s1;
	logic [CNT_W-1:0]              idx_s1;
	logic [IDX_W-1:0]              hit_idx_q;
	arrt_pkg::status_e_t           status_q;
	logic [ADDR_BITS-1:0]          hit_base_q;
	logic [ADDR_BITS-1:0]          hit_size_q;

	logic                          accept;
	logic                          full;
	logic                          rec_write;
	logic                          scan_issue;
	logic [CNT_W-1:0]              last_idx;
	logic [ADDR_BITS-1:0]          ent_base;
	logic [ADDR_BITS-1:0]          ent_size;
	logic [ADDR_BITS-1:0]          offset;
	logic                          entry_hit;
	logic                          scan_last;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign full       = (count_q >= MAX_CNT);
	assign rec_write  = accept && (arrt_pkg::func_e_t'(func) == arrt_pkg::FN_RECORD)
		&& (address != '0) && !full;
	assign last_idx   = count_q - CNT_W'(1);
	assign scan_issue = (state_q == S_SCAN) && (issue_q < count_q);

	assign rd_en   = scan_issue || (state_q == S_MOVE_RD);
	assign rd_idx  = (state_q == S_MOVE_RD) ? last_idx[IDX_W-1:0] : issue_q[IDX_W-1:0];
	assign wr_en   = rec_write || (state_q == S_MOVE_WR);
	assign wr_idx  = (state_q == S_MOVE_WR) ? hit_idx_q : count_q[IDX_W-1:0];
	assign wr_data = (state_q == S_MOVE_WR) ? rd_data : {address, region_size};

	assign ent_base  = rd_data[2*ADDR_BITS-1:ADDR_BITS];
	assign ent_size  = rd_data[ADDR_BITS-1:0];
	// The end of a range is never formed, so it cannot wrap.
	assign offset    = key_q - ent_base;
	assign entry_hit = (op_q == arrt_pkg::FN_LOOKUP)
		? ((key_q >= ent_base) && (offset < ent_size))
		: (key_q == ent_base);
	assign scan_last = (idx_s1 == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			op_q       <= arrt_pkg::FN_NONE;
			key_q      <= '0;
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			hit_idx_q  <= '0;
			status_q   <= arrt_pkg::ST_OK;
			hit_base_q <= '0;
			hit_size_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= arrt_pkg::func_e_t'(func);
						key_q      <= address;
						hit_base_q <= '0;
						hit_size_q <= '0;
						issue_q    <= '0;
						vld_s1     <= 1'b0;
						state_q    <= S_FINISH;
						case (arrt_pkg::func_e_t'(func))
							arrt_pkg::FN_RECORD: begin
								if (address == '0) begin
									status_q <= arrt_pkg::ST_ZERO_BASE;
								end else if (full) begin
									status_q <= arrt_pkg::ST_FULL;
								end else begin
									status_q <= arrt_pkg::ST_OK;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							arrt_pkg::FN_REMOVE, arrt_pkg::FN_LOOKUP: begin
								status_q <= arrt_pkg::ST_NOT_FOUND;
								if (count_q != '0) begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								status_q <= arrt_pkg::ST_OK;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Reads are issued ahead; a hit stops the scan and the
					// extra reads in flight are dropped.
					vld_s1 <= scan_issue;
					idx_s1 <= issue_q;
					if (scan_issue) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (entry_hit) begin
							if (op_q == arrt_pkg::FN_LOOKUP) begin
								status_q   <= arrt_pkg::ST_OK;
								hit_base_q <= ent_base;
								hit_size_q <= ent_size;
								state_q    <= S_FINISH;
							end else begin
								hit_idx_q <= idx_s1[IDX_W-1:0];
								state_q   <= S_MOVE_RD;
							end
						end else if (scan_last) begin
							status_q <= arrt_pkg::ST_NOT_FOUND;
							state_q  <= S_FINISH;
						end
					end
				end
				S_MOVE_RD: begin
					state_q <= S_MOVE_WR;
				end
				S_MOVE_WR: begin
					count_q  <= last_idx;
					status_q <= arrt_pkg::ST_OK;
					state_q  <= S_FINISH;
				end
				S_FINISH: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_ctl.done   = (state_q == S_FINISH);
	assign res_ctl.status = status_q;
	assign hit_base       = hit_base_q;
	assign hit_size       = hit_size_q;
	assign count          = count_q;

endmodule
`default_nettype wire

@@ design/allocation_range_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation range table
// Unordered table of heap regions with record, remove and lookup.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A record, or an unused function code,
// goes straight to the finish state and from there into the output register.
// Remove and lookup walk the entry memory one slot per cycle through its single
// read port, and a remove that hits then reads the last entry and writes it
// into the freed slot.
// The next item is accepted once the current one sits in the output register.
// The entry memory needs no clearing pass after reset.
module allocation_range_table #(
	parameter int MAX_ENTRIES = arrt_pkg::DEF_MAX_ENTRIES,
	parameter int ADDR_BITS   = arrt_pkg::DEF_ADDR_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [arrt_pkg::FUNC_W-1:0]   func,
	input  wire logic [ADDR_BITS-1:0]          address,
	input  wire logic [ADDR_BITS-1:0]          region_size,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic      [arrt_pkg::STATUS_W-1:0] status,
	output logic      [ADDR_BITS-1:0]          found_base,
	output logic      [ADDR_BITS-1:0]          found_size,
	output logic      [arrt_pkg::USED_W-1:0]   entries_used
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	arrt_pkg::res_ctl_t             res_ctl;
	logic                           res_take;
	logic [ADDR_BITS-1:0]           hit_base;
	logic [ADDR_BITS-1:0]           hit_size;
	logic [CNT_W-1:0]               count;
	logic                           wr_en;
	logic [IDX_W-1:0]               wr_idx;
	logic [2*ADDR_BITS-1:0]         wr_data;
	logic                           rd_en;
	logic [IDX_W-1:0]               rd_idx;
	logic [2*ADDR_BITS-1:0]         rd_data;

	logic                           rsp_valid_q;
	logic [arrt_pkg::STATUS_W-1:0]  status_q;
	logic [ADDR_BITS-1:0]           found_base_q;
	logic [ADDR_BITS-1:0]           found_size_q;
	logic [arrt_pkg::USED_W-1:0]    entries_used_q;

	arrt_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ADDR_BITS   (ADDR_BITS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.address     (address),
		.region_size (region_size),
		.res_ctl     (res_ctl),
		.res_take    (res_take),
		.hit_base    (hit_base),
		.hit_size    (hit_size),
		.count       (count),
		.wr_en       (wr_en),
		.wr_idx      (wr_idx),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data)
	);

	arrt_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (2 * ADDR_BITS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	// A finished item moves into the output register whenever it is empty
	// or being emptied in the same cycle.
	assign res_take = res_ctl.done && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q       <= res_ctl.status;
			found_base_q   <= hit_base;
			found_size_q   <= hit_size;
			entries_used_q <= arrt_pkg::USED_W'(count);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign found_base   = found_base_q;
	assign found_size   = found_size_q;
	assign entries_used = entries_used_q;

endmodule
`default_nettype wire

@@ verif/tb_allocation_range_table.sv @@
// ----------------------------------------------------------------------------
// Allocation range table testbench
// Drives record, remove and lookup items through the request channel and checks
// every response against a typed result or a behavioral copy of the region table.
// A short table of directed items comes first. Random traffic follows on a
// small table that is drained now and then.
// ----------------------------------------------------------------------------
module tb_allocation_range_table;
	import arrt_pkg::*;

	localparam int ADDR_W = DEF_ADDR_BITS;
	localparam int SLOTS = DEF_MAX_ENTRIES;
	localparam logic [ADDR_W-1:0] TOP_ADDR = '1;
	localparam int MIXED_ITEMS = 556;
	localparam int SMALL_CAP = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int FIRST_HOLD_AT = 60;
	localparam int SECOND_HOLD_AT = 400;
	localparam int DRAIN_CYCLES = 1100;
	localparam int MAX_REPORTS = 200;
	localparam longint TIMEOUT = 80_000_000;

	typedef struct packed {
		status_e_t         status;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] size;
		logic [USED_W-1:0] used;
	} table_rsp_t;

	typedef struct {
		func_e_t           op;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] len;
		bit                typed;
		table_rsp_t        rsp;
	} stim_row_t;

	localparam table_rsp_t UNTYPED = '0;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic [FUNC_W-1:0]   func;
	logic [ADDR_W-1:0]   address;
	logic [ADDR_W-1:0]   region_size;
	logic                rsp_valid;
	logic                rsp_ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   found_base;
	logic [ADDR_W-1:0]   found_size;
	logic [USED_W-1:0]   entries_used;

	// Shadow copy of the region table.
	logic [ADDR_W-1:0] region_base_q [SLOTS];
	logic [ADDR_W-1:0] region_size_q [SLOTS];
	int held_regions = 0;

	table_rsp_t awaited_rsp [$];
	stim_row_t  directed_rows [$];

	int burst_left = 0;
	int items_sent = 0;
	int results_checked = 0;
	int fail_count = 0;
	int lookup_hits = 0;
	int peak_regions = 0;

	allocation_range_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.func         (func),
		.address      (address),
		.region_size  (region_size),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.status       (status),
		.found_base   (found_base),
		.found_size   (found_size),
		.entries_used (entries_used)
	);

	always #5 clk = ~clk;

	function automatic table_rsp_t predict_region_op(func_e_t op, logic [ADDR_W-1:0] a,
			logic [ADDR_W-1:0] len);
		table_rsp_t r;
		int i;
		int last;
		r = '0;
		r.status = ST_OK;
		case (op)
		FN_RECORD: begin
			if (a == '0) begin
				r.status = ST_ZERO_BASE;
			end else if (held_regions >= SLOTS) begin
				r.status = ST_FULL;
			end else begin
				region_base_q[held_regions] = a;
				region_size_q[held_regions] = len;
				held_regions++;
			end
		end
		FN_REMOVE: begin
			r.status = ST_NOT_FOUND;
			for (i = 0; i < held_regions; i++) begin
				if (region_base_q[i] == a) begin
					last = held_regions - 1;
					region_base_q[i] = region_base_q[last];
					region_size_q[i] = region_size_q[last];
					held_regions = last;
					r.status = ST_OK;
					break;
				end
			end
		end
		FN_LOOKUP: begin
			r.status = ST_NOT_FOUND;
			for (i = 0; i < held_regions; i++) begin
				// The difference form never builds base + size, so it cannot wrap.
				if (a >= region_base_q[i] && (a - region_base_q[i]) < region_size_q[i]) begin
					r.status = ST_OK;
					r.base = region_base_q[i];
					r.size = region_size_q[i];
					lookup_hits++;
					break;
				end
			end
		end
		default: begin
		end
		endcase
		r.used = USED_W'(held_regions);
		if (held_regions > peak_regions)
			peak_regions = held_regions;
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] rand_base();
		logic [ADDR_W-1:0] b;
		if ($urandom_range(0, 2) == 0)
			b = ADDR_W'($urandom_range(1, 65535));
		else
			b = rand_addr();
		if (b == '0)
			b = 'd1;
		return b;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_len();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return TOP_ADDR;
		2, 3: return rand_addr();
		default: return ADDR_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// Probe around a held region: its base, last byte, one past its end, or inside.
	function automatic logic [ADDR_W-1:0] probe_near(int idx);
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] n;
		b = region_base_q[idx];
		n = region_size_q[idx];
		case ($urandom_range(0, 3))
		0: return b;
		1: return b + n;
		2: return b + n - 1'b1;
		default: return (n == '0) ? b : b + rand_addr() % n;
		endcase
	endfunction

	task automatic offer_item(input func_e_t op, input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] len, input bit typed, input table_rsp_t typed_rsp);
		table_rsp_t predicted;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		func <= op;
		address <= a;
		region_size <= len;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = predict_region_op(op, a, len);
		awaited_rsp.push_back(typed ? typed_rsp : predicted);
		items_sent++;
	endtask

	// A cap of zero turns records into removes, mostly of held bases, draining the table.
	task automatic offer_mixed(input int cap);
		int pick;
		int r;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 40 && held_regions >= cap)
			pick = 40;
		r = $urandom_range(0, 19);
		if (pick < 40) begin
			if (r == 0)
				a = '0;
			else if (r < 4 && held_regions > 0)
				a = region_base_q[$urandom_range(0, held_regions - 1)];
			else
				a = rand_base();
			offer_item(FN_RECORD, a, rand_len(), 1'b0, UNTYPED);
		end else if (pick < 62) begin
			if (r < 14 && held_regions > 0)
				a = region_base_q[$urandom_range(0, held_regions - 1)];
			else if (r < 17)
				a = '0;
			else
				a = rand_addr();
			offer_item(FN_REMOVE, a, rand_addr(), 1'b0, UNTYPED);
		end else if (pick < 95) begin
			if (r < 15 && held_regions > 0)
				a = probe_near($urandom_range(0, held_regions - 1));
			else
				a = rand_addr();
			offer_item(FN_LOOKUP, a, rand_addr(), 1'b0, UNTYPED);
		end else begin
			offer_item(FN_NONE, rand_addr(), rand_addr(), 1'b0, UNTYPED);
		end
	endtask

	task automatic check_result();
		table_rsp_t got;
		table_rsp_t want;
		got = '{status_e_t'(status), found_base, found_size, entries_used};
		results_checked++;
		if (awaited_rsp.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: unexpected result, actual %s base %h size %h used %0d",
					$time, got.status.name(), got.base, got.size, got.used);
		end else begin
			want = awaited_rsp.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: mismatch, expected %s %h/%h/%0d, actual %s %h/%h/%0d",
						$time, want.status.name(), want.base, want.size, want.used,
						got.status.name(), got.base, got.size, got.used);
			end
		end
	endtask

	// Response side: stalls follow changing modes, with two long hold-offs that
	// back the block up while items keep being offered.
	initial begin
		int mode;
		int mode_left;
		int hold_idx;
		bit toggle;
		mode = 0;
		mode_left = 0;
		hold_idx = 0;
		toggle = 1'b0;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready)
				check_result();
			if ((hold_idx == 0 && results_checked == FIRST_HOLD_AT) ||
					(hold_idx == 1 && results_checked == SECOND_HOLD_AT)) begin
				hold_idx++;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= ($urandom_range(0, 3) != 0);
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					toggle = !toggle;
					rsp_ready <= toggle;
				end
				endcase
			end
		end
	end

	initial begin
		int n;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		func <= FN_NONE;
		address <= '0;
		region_size <= '0;

		directed_rows = '{
			'{FN_LOOKUP, 48'h0, 48'h0, 1'b1, '{ST_NOT_FOUND, 48'h0, 48'h0, 11'd0}},
			'{FN_REMOVE, 48'h0, 48'h0, 1'b1, '{ST_NOT_FOUND, 48'h0, 48'h0, 11'd0}},
			'{FN_RECORD, 48'h0, 48'h5, 1'b1, '{ST_ZERO_BASE, 48'h0, 48'h0, 11'd0}},
			'{FN_NONE, TOP_ADDR, TOP_ADDR, 1'b1, '{ST_OK, 48'h0, 48'h0, 11'd0}},
			'{FN_RECORD, 48'h1, TOP_ADDR, 1'b1, '{ST_OK, 48'h0, 48'h0, 11'd1}},
			'{FN_RECORD, TOP_ADDR, 48'h1, 1'b1, '{ST_OK, 48'h0, 48'h0, 11'd2}},
			'{FN_RECORD, 48'h1000, 48'h0, 1'b1, '{ST_OK, 48'h0, 48'h0, 11'd3}},
			'{FN_LOOKUP, 48'h0, 48'h0, 1'b1, '{ST_NOT_FOUND, 48'h0, 48'h0, 11'd3}},
			// The first region ends at the top of the address space.
			'{FN_LOOKUP, TOP_ADDR, 48'h0, 1'b1, '{ST_OK, 48'h1, TOP_ADDR, 11'd3}},
			'{FN_LOOKUP, 48'h1000, 48'h0, 1'b0, UNTYPED},
			'{FN_REMOVE, 48'h1, 48'h0, 1'b1, '{ST_OK, 48'h0, 48'h0, 11'd2}},
			// The moved zero-size region must not match its own base.
			'{FN_LOOKUP, 48'h1000, 48'h0, 1'b0, UNTYPED},
			'{FN_LOOKUP, TOP_ADDR, 48'h0, 1'b0, UNTYPED},
			'{FN_RECORD, TOP_ADDR, TOP_ADDR, 1'b0, UNTYPED},
			'{FN_REMOVE, TOP_ADDR, 48'h0, 1'b0, UNTYPED},
			'{FN_LOOKUP, TOP_ADDR, 48'h0, 1'b0, UNTYPED},
			'{FN_REMOVE, 48'h1234, 48'h0, 1'b1, '{ST_NOT_FOUND, 48'h0, 48'h0, 11'd2}},
			'{FN_RECORD, 48'h5000, 48'h100, 1'b0, UNTYPED},
			'{FN_LOOKUP, 48'h50ff, 48'h0, 1'b0, UNTYPED},
			'{FN_LOOKUP, 48'h5100, 48'h0, 1'b0, UNTYPED},
			'{FN_LOOKUP, 48'h5000, 48'h0, 1'b0, UNTYPED},
			'{FN_NONE, 48'h0, 48'h0, 1'b0, UNTYPED},
			'{FN_REMOVE, 48'h1000, 48'h0, 1'b0, UNTYPED},
			'{FN_LOOKUP, 48'h5080, 48'h0, 1'b0, UNTYPED}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			offer_item(directed_rows[k].op, directed_rows[k].a, directed_rows[k].len,
				directed_rows[k].typed, directed_rows[k].rsp);

		for (n = 0; n < MIXED_ITEMS; n++)
			offer_mixed((n % 150 >= 110) ? 0 : SMALL_CAP);
		req_valid <= 1'b0;

		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d results; %0d lookups hit a region.",
			items_sent, results_checked, lookup_hits);
		$display("The table peaked at %0d regions and was drained several times.",
			peak_regions);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
